### rtl/ipv4hp_pkg.sv
// Shared types and constants for the IPv4 header parser and checker.
`default_nettype none

package ipv4hp_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_SHORT_HLEN  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_CSUM_BAD    = 3'd4
  } status_e;

  localparam logic [3:0] IpVersion      = 4'd4;
  localparam logic [3:0] MinHeaderWords = 4'd5;

  // byte positions within the header
  localparam logic [5:0] CsumLoIdx    = 6'd11;
  localparam logic [5:0] FixedLastIdx = 6'd19;
  localparam logic [5:0] MaxHeaderIdx = 6'd59;

  typedef struct packed {
    status_e     status;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic        dont_fragment;
    logic        more_fragments;
    logic [12:0] fragment_offset;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_num;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } result_t;

endpackage

`default_nettype wire

### rtl/ipv4_header_parser_checker.sv
// Top level of the IPv4 header parser and checksum checker.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | in        | in_valid_i / in_stall_o | data_byte, start/end_of_packet
//   out     | out       | out_valid_o / out_stall_i | status and parsed header fields
//
// One byte per cycle is accepted while in_stall_o is low; a byte lands in the
// input register, is parsed there, and its result (if any) goes to the output register.
// Reset clears the parser state; no clearing pass is needed.
// A stalled result holds the input register, so in_stall_o rises in the same cycle while a byte waits there.
`default_nettype none

module ipv4_header_parser_checker import ipv4hp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_of_packet_i,
  input  wire logic        end_of_packet_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [3:0]       header_words_o,
  output logic [7:0]       service_type_o,
  output logic [15:0]      total_length_o,
  output logic [15:0]      ident_o,
  output logic             dont_fragment_o,
  output logic             more_fragments_o,
  output logic [12:0]      fragment_offset_o,
  output logic [7:0]       time_to_live_o,
  output logic [7:0]       protocol_num_o,
  output logic [31:0]      source_addr_o,
  output logic [31:0]      dest_addr_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_sop_q;
  logic       s1_eop_q;
  logic       in_xfer;
  logic       advance;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance    = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_byte_q <= '0;
      s1_sop_q  <= 1'b0;
      s1_eop_q  <= 1'b0;
    end else if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_sop_q  <= start_of_packet_i;
      s1_eop_q  <= end_of_packet_i;
    end
  end

  ipv4hp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (s1_byte_q),
    .sop_i       (s1_sop_q),
    .eop_i       (s1_eop_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ipv4hp_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res)
  );

  assign status_o          = out_res.status;
  assign header_words_o    = out_res.header_words;
  assign service_type_o    = out_res.service_type;
  assign total_length_o    = out_res.total_length;
  assign ident_o           = out_res.ident;
  assign dont_fragment_o   = out_res.dont_fragment;
  assign more_fragments_o  = out_res.more_fragments;
  assign fragment_offset_o = out_res.fragment_offset;
  assign time_to_live_o    = out_res.time_to_live;
  assign protocol_num_o    = out_res.protocol_num;
  assign source_addr_o     = out_res.source_addr;
  assign dest_addr_o       = out_res.dest_addr;

  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_stalled_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_sop_q))
    else $error("held byte lost while output blocked");

endmodule

`default_nettype wire

### rtl/ipv4hp_parse.sv
// Header field capture, running checksum and result decision for one byte.
`default_nettype none

module ipv4hp_parse import ipv4hp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       sop_i,
  input  wire logic       eop_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  logic        in_header_q;
  logic [5:0]  byte_index_q;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [3:0]  ver_q, ver_d;
  logic [3:0]  hlen_q, hlen_d;
  logic [7:0]  tos_q, tos_d;
  logic [15:0] len_q, len_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] csum_q, csum_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        active;
  logic [5:0]  idx;
  logic [7:0]  hold_base;
  logic [16:0] word_sum;
  logic        last_byte;
  logic        emit;
  status_e     status;

  always_comb begin
    active    = sop_i | in_header_q;
    idx       = sop_i ? '0 : byte_index_q;
    hold_base = sop_i ? '0 : hold_q;
    sum_d     = sop_i ? '0 : sum_q;
    ver_d     = sop_i ? '0 : ver_q;
    hlen_d    = sop_i ? '0 : hlen_q;
    tos_d     = sop_i ? '0 : tos_q;
    len_d     = sop_i ? '0 : len_q;
    ident_d   = sop_i ? '0 : ident_q;
    frag_d    = sop_i ? '0 : frag_q;
    ttl_d     = sop_i ? '0 : ttl_q;
    proto_d   = sop_i ? '0 : proto_q;
    csum_d    = sop_i ? '0 : csum_q;
    src_d     = sop_i ? '0 : src_q;
    dst_d     = sop_i ? '0 : dst_q;
    hold_d    = hold_base;

    unique case (idx)
      6'd0: begin
        ver_d  = data_byte_i[7:4];
        hlen_d = data_byte_i[3:0];
      end
      6'd1:                      tos_d   = data_byte_i;
      6'd2, 6'd3:                len_d   = {len_d[7:0], data_byte_i};
      6'd4, 6'd5:                ident_d = {ident_d[7:0], data_byte_i};
      6'd6, 6'd7:                frag_d  = {frag_d[7:0], data_byte_i};
      6'd8:                      ttl_d   = data_byte_i;
      6'd9:                      proto_d = data_byte_i;
      6'd10, 6'd11:              csum_d  = {csum_d[7:0], data_byte_i};
      6'd12, 6'd13, 6'd14, 6'd15: src_d  = {src_d[23:0], data_byte_i};
      6'd16, 6'd17, 6'd18, 6'd19: dst_d  = {dst_d[23:0], data_byte_i};
      default: ;
    endcase

    // ones'-complement add with end-around carry; checksum word excluded
    word_sum = {1'b0, sum_d} + {1'b0, hold_base, data_byte_i};
    if (!idx[0]) begin
      hold_d = data_byte_i;
    end else if (idx != CsumLoIdx) begin
      sum_d = word_sum[15:0] + {15'd0, word_sum[16]};
    end

    last_byte = (({1'b0, idx} + 7'd1) == {1'b0, hlen_d, 2'b00});

    emit   = 1'b1;
    status = ST_OK;
    priority if (idx == FixedLastIdx && ver_d != IpVersion) begin
      status = ST_BAD_VERSION;
    end else if (idx == FixedLastIdx && hlen_d < MinHeaderWords) begin
      status = ST_SHORT_HLEN;
    end else if (idx >= FixedLastIdx && last_byte) begin
      status = ((~sum_d) == csum_d) ? ST_OK : ST_CSUM_BAD;
    end else if (eop_i) begin
      status = ST_TRUNCATED;
    end else begin
      emit = 1'b0;
    end

    res_valid_o = active & emit;

    res_o.status          = status;
    res_o.header_words    = hlen_d;
    res_o.service_type    = tos_d;
    res_o.total_length    = len_d;
    res_o.ident           = ident_d;
    res_o.dont_fragment   = frag_d[14];
    res_o.more_fragments  = frag_d[13];
    res_o.fragment_offset = frag_d[12:0];
    res_o.time_to_live    = ttl_d;
    res_o.protocol_num    = proto_d;
    res_o.source_addr     = src_d;
    res_o.dest_addr       = dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q  <= 1'b0;
      byte_index_q <= '0;
      sum_q        <= '0;
      hold_q       <= '0;
      ver_q        <= '0;
      hlen_q       <= '0;
      tos_q        <= '0;
      len_q        <= '0;
      ident_q      <= '0;
      frag_q       <= '0;
      ttl_q        <= '0;
      proto_q      <= '0;
      csum_q       <= '0;
      src_q        <= '0;
      dst_q        <= '0;
    end else if (advance_i && active) begin
      in_header_q  <= ~emit;
      byte_index_q <= emit ? '0 : idx + 6'd1;
      sum_q        <= sum_d;
      hold_q       <= hold_d;
      ver_q        <= ver_d;
      hlen_q       <= hlen_d;
      tos_q        <= tos_d;
      len_q        <= len_d;
      ident_q      <= ident_d;
      frag_q       <= frag_d;
      ttl_q        <= ttl_d;
      proto_q      <= proto_d;
      csum_q       <= csum_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
    end
  end

  a_idle_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_header_q |-> byte_index_q == '0)
    else $error("byte index nonzero outside a header");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_header_q |-> byte_index_q <= MaxHeaderIdx)
    else $error("byte index past the longest header");

  a_result_ends_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o |=> !in_header_q)
    else $error("header still open after its result");

endmodule

`default_nettype wire

### rtl/ipv4hp_outreg.sv
// Result register holding one parsed header until the output transfer.
`default_nettype none

module ipv4hp_outreg import ipv4hp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  input  wire logic    out_stall_i,
  output logic         free_o,
  output logic         out_valid_o,
  output result_t      out_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    free_o  = ~valid_q | ~out_stall_i;
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i & res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire
